[design/ipv4tfb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4tfb_pkg
// Shared types and constants of the IPv4 test frame builder.
// ----------------------------------------------------------------------------
package ipv4tfb_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 2048;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IN_DATA_W  = 80;   // 64 random + 16 ident
    localparam int OUT_DATA_W = 72;   // 64 word + 4 count, padded

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEST_ADDRESS = 3'd0,
        CFG_DEST_PORT    = 3'd1,
        CFG_SPORT_LOW    = 3'd2,
        CFG_SPORT_HIGH   = 3'd3,
        CFG_KIND         = 3'd4,
        CFG_FRAME_BYTES  = 3'd5,
        CFG_DSCP         = 3'd6,
        CFG_FILL_MODE    = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_UDP  = 2'd0,
        KIND_TCP  = 2'd1,
        KIND_ICMP = 2'd2,
        KIND_ALT  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        FILL_RANDOM = 2'd0,
        FILL_ZEROS  = 2'd1,
        FILL_ONES   = 2'd2,
        FILL_COUNT  = 2'd3
    } fill_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;       // first beat: latch inputs, start port divide
        logic div_step;
        logic emit_live;     // build a word from the beat on the bus
        logic emit_latched;  // build word 0 from latched beat
    } ctrl_cmd_t;

    typedef struct packed {
        logic first_word;
        logic div_done;
        logic out_free;
    } dp_status_t;

    localparam logic [31:0] OWN_IP_ADDR = 32'hC0A80101;
    localparam logic [7:0]  TTL_VAL     = 8'd64;

endpackage
`default_nettype wire

[design/ipv4_test_frame_builder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_test_frame_builder_unit
// Builds Ethernet/IPv4 test frames (UDP, TCP SYN or ICMP echo), one 64-bit
// big-endian word per input beat.
//
//  channel  dir  payload
//  s_*      in   tdata[63:0] random_bits, tdata[79:64] echo_ident
//  m_*      out  tdata[63:0] frame_word, tdata[67:64] valid_bytes, tlast eof
//  cfg_*    in   register index 0..7, write data 32 bits
//
// Words after the first of a frame are each held in one output register. The
// first beat of a frame runs capture, the bit-serial remainder that picks the
// source port, divide done and emit, in turn. aresetn is synchronous; it restores
// register defaults and restarts framing. A stalled output holds the next beat
// off at the input.
// ----------------------------------------------------------------------------
module ipv4_test_frame_builder_unit #(
    parameter int MAX_FRAME_BYTES = ipv4tfb_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [ipv4tfb_pkg::CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [ipv4tfb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [ipv4tfb_pkg::IN_DATA_W-1:0]    s_tdata,  // random_bits, echo_ident
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [ipv4tfb_pkg::OUT_DATA_W-1:0]        m_tdata,  // frame_word, valid_bytes, pad
    output logic                                     m_tlast
);
    import ipv4tfb_pkg::*;

    ctrl_cmd_t   cmd;
    dp_status_t  status;
    logic [63:0] out_word;
    logic [3:0]  out_count;

    ipv4tfb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ipv4tfb_dp #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .rnd_in    (s_tdata[63:0]),
        .ident_in  (s_tdata[79:64]),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_word  (out_word),
        .out_count (out_count),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'd0, out_count, out_word};

endmodule
`default_nettype wire

[design/ipv4tfb_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4tfb_ctrl
// Sequencer: first beat of a frame runs the source port divide, then emits.
// ----------------------------------------------------------------------------
module ipv4tfb_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire ipv4tfb_pkg::dp_status_t status,
    output ipv4tfb_pkg::ctrl_cmd_t      cmd
);
    import ipv4tfb_pkg::*;

    state_t state_reg, state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE) && status.out_free;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && status.first_word) state_next = ST_DIV;
            end
            ST_DIV: begin
                if (status.div_done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.capture   = accept && status.first_word;
                cmd.emit_live = accept && !status.first_word;
            end
            ST_DIV: begin
                cmd.div_step = !status.div_done;
            end
            ST_EMIT: begin
                cmd.emit_latched = status.out_free;
            end
            default: cmd = '0;
        endcase
    end

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input taken while a frame start is in progress");

    a_div_to_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && status.div_done) |=> (state_reg == ST_EMIT))
        else $error("divide finished without emit");

    a_capture_once: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> (state_reg == ST_DIV))
        else $error("capture did not start divide");

endmodule
`default_nettype wire

[design/ipv4tfb_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4tfb_dp
// Datapath: config registers, per-frame latches, port divider, word builder
// and output register.
// ----------------------------------------------------------------------------
module ipv4tfb_dp #(
    parameter int MAX_FRAME_BYTES = ipv4tfb_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [ipv4tfb_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [ipv4tfb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic [63:0]                       rnd_in,
    input  wire logic [15:0]                       ident_in,
    input  wire ipv4tfb_pkg::ctrl_cmd_t             cmd,
    output ipv4tfb_pkg::dp_status_t                status,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [63:0]                            out_word,
    output logic [3:0]                             out_count,
    output logic                                   out_last
);
    import ipv4tfb_pkg::*;

    localparam int LEN_LIMIT = (MAX_FRAME_BYTES < 1514) ? MAX_FRAME_BYTES : 1514;

    // configuration
    logic [31:0] dest_addr_reg;
    logic [15:0] dest_port_reg, sport_low_reg, sport_high_reg;
    logic [1:0]  kind_reg, fill_reg;
    logic [10:0] frame_bytes_reg;
    logic [5:0]  dscp_reg;

    // frame state
    logic [7:0]  word_idx_reg;
    logic [31:0] seq_reg;
    logic [15:0] sport_reg, hsum_reg, ident_reg;
    logic [10:0] len_reg;
    logic [63:0] rnd_reg;

    // divider
    logic [4:0]  div_cnt_reg;
    logic [16:0] div_rem_reg, span_reg;
    logic [15:0] div_dvd_reg;
    logic [16:0] rem_sh;

    // output register
    logic        out_valid_reg;
    logic [63:0] word_reg;
    logic [3:0]  count_reg;
    logic        last_reg;

    logic [10:0] clamp_len;
    logic [16:0] span_now;
    logic [18:0] sum_raw;
    logic [16:0] sum_f1;
    logic [15:0] sum_f2;
    logic [7:0]  proto_now;

    logic        emit;
    logic [63:0] rnd_sel;
    logic [10:0] len_sel, base, remain;
    logic [15:0] hsum_sel, sport_sel, ident_sel;
    logic        last_now;
    logic [3:0]  count_now;
    logic [63:0] word_now;

    function automatic logic [7:0] frame_byte(
        input logic [10:0] pos, input logic [10:0] len, input logic [1:0] kind,
        input logic [5:0] dscp, input logic [15:0] hsum, input logic [31:0] daddr,
        input logic [15:0] sport, input logic [15:0] dport, input logic [1:0] fill,
        input logic [31:0] seq, input logic [15:0] ident, input logic [7:0] rbyte,
        input logic [7:0] proto);
        logic [10:0] ip_len, udp_len, cnt;
        logic [7:0]  b;
        ip_len  = len - 11'd14;
        udp_len = len - 11'd34;
        cnt     = pos - 11'd42;
        b       = 8'h00;
        priority case (pos)
            11'd0, 11'd6: b = 8'h00;
            11'd1: b = 8'hAA;
            11'd2: b = 8'hBB;
            11'd3: b = 8'hCC;
            11'd4: b = 8'hDD;
            11'd5: b = 8'hEE;
            11'd7: b = 8'h11;
            11'd8: b = 8'h22;
            11'd9: b = 8'h33;
            11'd10: b = 8'h44;
            11'd11: b = 8'h55;
            11'd12: b = 8'h08;
            11'd13: b = 8'h00;
            11'd14: b = 8'h45;
            11'd15: b = {dscp, 2'b00};
            11'd16: b = {5'd0, ip_len[10:8]};
            11'd17: b = ip_len[7:0];
            11'd22: b = TTL_VAL;
            11'd23: b = proto;
            11'd24: b = hsum[15:8];
            11'd25: b = hsum[7:0];
            11'd26: b = OWN_IP_ADDR[31:24];
            11'd27: b = OWN_IP_ADDR[23:16];
            11'd28: b = OWN_IP_ADDR[15:8];
            11'd29: b = OWN_IP_ADDR[7:0];
            11'd30: b = daddr[31:24];
            11'd31: b = daddr[23:16];
            11'd32: b = daddr[15:8];
            11'd33: b = daddr[7:0];
            default: begin
                if (pos < 11'd34) begin
                    b = 8'h00;
                end else if (kind == KIND_UDP) begin
                    priority if (pos == 11'd34) b = sport[15:8];
                    else if (pos == 11'd35) b = sport[7:0];
                    else if (pos == 11'd36) b = dport[15:8];
                    else if (pos == 11'd37) b = dport[7:0];
                    else if (pos == 11'd38) b = {5'd0, udp_len[10:8]};
                    else if (pos == 11'd39) b = udp_len[7:0];
                    else if (pos < 11'd42) b = 8'h00;
                    else begin
                        unique case (fill)
                            FILL_RANDOM: b = rbyte;
                            FILL_ZEROS:  b = 8'h00;
                            FILL_ONES:   b = 8'hFF;
                            FILL_COUNT:  b = cnt[7:0];
                            default:     b = 8'h00;
                        endcase
                    end
                end else if (kind == KIND_TCP) begin
                    priority if (pos == 11'd34) b = sport[15:8];
                    else if (pos == 11'd35) b = sport[7:0];
                    else if (pos == 11'd36) b = dport[15:8];
                    else if (pos == 11'd37) b = dport[7:0];
                    else if (pos == 11'd38) b = seq[31:24];
                    else if (pos == 11'd39) b = seq[23:16];
                    else if (pos == 11'd40) b = seq[15:8];
                    else if (pos == 11'd41) b = seq[7:0];
                    else if (pos == 11'd46) b = 8'h50;
                    else if (pos == 11'd47) b = 8'h02;
                    else if (pos == 11'd48 || pos == 11'd49) b = 8'hFF;
                    else b = 8'h00;
                end else begin
                    priority if (pos == 11'd34) b = 8'h08;
                    else if (pos == 11'd38) b = ident[15:8];
                    else if (pos == 11'd39) b = ident[7:0];
                    else if (pos == 11'd40) b = seq[15:8];
                    else if (pos == 11'd41) b = seq[7:0];
                    else b = 8'h00;
                end
            end
        endcase
        return b;
    endfunction

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dest_addr_reg   <= 32'hC0A80202;
            dest_port_reg   <= 16'd5000;
            sport_low_reg   <= 16'd10000;
            sport_high_reg  <= 16'd10100;
            kind_reg        <= KIND_UDP;
            frame_bytes_reg <= 11'd1400;
            dscp_reg        <= 6'd0;
            fill_reg        <= FILL_COUNT;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_DEST_ADDRESS: dest_addr_reg   <= cfg_wdata;
                CFG_DEST_PORT:    dest_port_reg   <= cfg_wdata[15:0];
                CFG_SPORT_LOW:    sport_low_reg   <= cfg_wdata[15:0];
                CFG_SPORT_HIGH:   sport_high_reg  <= cfg_wdata[15:0];
                CFG_KIND:         kind_reg        <= cfg_wdata[1:0];
                CFG_FRAME_BYTES:  frame_bytes_reg <= cfg_wdata[10:0];
                CFG_DSCP:         dscp_reg        <= cfg_wdata[5:0];
                CFG_FILL_MODE:    fill_reg        <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // per-frame header values
    always_comb begin
        clamp_len = frame_bytes_reg;
        if (clamp_len < 11'd60) clamp_len = 11'd60;
        if (clamp_len > 11'(LEN_LIMIT)) clamp_len = 11'(LEN_LIMIT);
        span_now = (sport_high_reg >= sport_low_reg)
                 ? ({1'b0, sport_high_reg} - {1'b0, sport_low_reg} + 17'd1) : 17'd1;
        unique case (kind_reg)
            KIND_UDP: proto_now = 8'd17;
            KIND_TCP: proto_now = 8'd6;
            default:  proto_now = 8'd1;
        endcase
        sum_raw = 19'({8'h45, dscp_reg, 2'b00}) + 19'(clamp_len - 11'd14)
                + 19'({8'h40, proto_now}) + 19'(OWN_IP_ADDR[31:16])
                + 19'(OWN_IP_ADDR[15:0])
                + 19'(dest_addr_reg[31:16]) + 19'(dest_addr_reg[15:0]);
        sum_f1 = 17'(sum_raw[15:0]) + 17'(sum_raw[18:16]);
        sum_f2 = sum_f1[15:0] + 16'(sum_f1[16]);
    end

    // restoring divide for the source port remainder, one bit a cycle
    assign rem_sh = {div_rem_reg[15:0], div_dvd_reg[15]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (cmd.capture) begin
            div_cnt_reg <= 5'd16;
        end else if (cmd.div_step) begin
            div_cnt_reg <= div_cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            div_rem_reg <= '0;
            div_dvd_reg <= rnd_in[15:0];
            span_reg    <= span_now;
            rnd_reg     <= rnd_in;
            ident_reg   <= ident_in;
            len_reg     <= clamp_len;
            hsum_reg    <= ~sum_f2;
        end else if (cmd.div_step) begin
            div_rem_reg <= (rem_sh >= span_reg) ? (rem_sh - span_reg) : rem_sh;
            div_dvd_reg <= {div_dvd_reg[14:0], 1'b0};
        end
        if (cmd.emit_latched) begin
            sport_reg <= sport_low_reg + div_rem_reg[15:0];
        end
    end

    // word builder
    assign emit      = cmd.emit_live || cmd.emit_latched;
    assign rnd_sel   = cmd.emit_latched ? rnd_reg : rnd_in;
    assign len_sel   = len_reg;
    assign hsum_sel  = hsum_reg;
    assign ident_sel = ident_reg;
    assign sport_sel = cmd.emit_latched ? (sport_low_reg + div_rem_reg[15:0]) : sport_reg;
    assign base      = {word_idx_reg, 3'b000};
    assign remain    = (len_sel > base) ? (len_sel - base) : 11'd1;
    assign last_now  = remain <= 11'd8;
    assign count_now = last_now ? remain[3:0] : 4'd8;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            if (4'(k) < count_now) begin
                word_now[63-8*k -: 8] = frame_byte(base + 11'(k), len_sel, kind_reg,
                    dscp_reg, hsum_sel, dest_addr_reg, sport_sel, dest_port_reg,
                    fill_reg, seq_reg, ident_sel, rnd_sel[63-8*k -: 8], proto_now);
            end else begin
                word_now[63-8*k -: 8] = 8'h00;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_idx_reg  <= '0;
            seq_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                out_valid_reg <= 1'b1;
                if (last_now) begin
                    word_idx_reg <= '0;
                    seq_reg      <= seq_reg + 32'd1;
                end else begin
                    word_idx_reg <= word_idx_reg + 8'd1;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            word_reg  <= word_now;
            count_reg <= count_now;
            last_reg  <= last_now;
        end
    end

    assign status.first_word = (word_idx_reg == 8'd0);
    assign status.div_done   = (div_cnt_reg == 5'd0);
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid  = out_valid_reg;
    assign out_word  = word_reg;
    assign out_count = count_reg;
    assign out_last  = last_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (count_reg != 4'd0 && count_reg <= 4'd8))
        else $error("byte count out of range");

    a_full_unless_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !last_reg) |-> (count_reg == 4'd8))
        else $error("short word before frame end");

    a_last_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && last_now) |=> (word_idx_reg == 8'd0))
        else $error("word index not cleared after last word");

    a_rem_below_span: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.div_step && div_cnt_reg == 5'd1) |=> (div_rem_reg < span_reg))
        else $error("divider remainder not below span");

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of ipv4_test_frame_builder_unit. Random beats go in and are
// acceptance-predicted by a frame byte model kept in the bench. Each output
// beat is then compared with the oldest predicted word. Register writes
// happen only while the unit is drained, and some of them fall mid-frame.
// ----------------------------------------------------------------------------
module tb_top;
    import ipv4tfb_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    cfg_idx_t    cfg_addr = CFG_DEST_ADDRESS;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;   // random_bits, echo_ident
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;        // frame_word, valid_bytes, pad
    logic        m_tlast;

    ipv4_test_frame_builder_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // shadow registers
    logic [31:0] dest_addr_q;
    logic [15:0] dest_port_q, sport_lo_q, sport_hi_q;
    kind_t       kind_q;
    logic [10:0] frame_len_q;
    logic [5:0]  dscp_q;
    fill_t       fill_q;
    // framing state
    logic [7:0]  word_idx;
    logic [31:0] frame_seq;
    logic [15:0] lat_sport, lat_csum, lat_ident;
    logic [10:0] lat_len;

    typedef struct packed {
        logic        eof;
        logic [71:0] data;
    } frame_beat_t;

    frame_beat_t expected_words[$];
    int  errors = 0;
    int  beats_in = 0;
    int  beats_out = 0;
    int  frames_out = 0;
    int  idle_cycles = 0;
    bit  steady = 1'b0;   // no idling on either side while set

    function automatic logic [7:0] proto_of(kind_t k);
        case (k)
            KIND_UDP: return 8'd17;
            KIND_TCP: return 8'd6;
            default:  return 8'd1;
        endcase
    endfunction

    function automatic logic [15:0] ip_checksum(logic [10:0] len);
        logic [31:0] s;
        s = 32'h4500 | {24'd0, dscp_q, 2'b00};
        s += {16'd0, 16'(len - 11'd14)};
        s += 32'h4000 | {24'd0, proto_of(kind_q)};
        s += 32'hC0A8 + 32'h0101;
        s += {16'd0, dest_addr_q[31:16]} + {16'd0, dest_addr_q[15:0]};
        s = {16'd0, s[15:0]} + (s >> 16);
        s = {16'd0, s[15:0]} + (s >> 16);
        return ~s[15:0];
    endfunction

    function automatic logic [7:0] byte_at(int pos, logic [63:0] rnd, int lane);
        logic [15:0] ip_len, udp_len;
        logic [7:0]  mac [14];
        mac = '{8'h00, 8'hAA, 8'hBB, 8'hCC, 8'hDD, 8'hEE,
                8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h08, 8'h00};
        ip_len  = 16'(lat_len) - 16'd14;
        udp_len = 16'(lat_len) - 16'd34;
        if (pos < 14) return mac[pos];
        case (pos)
            14: return 8'h45;
            15: return {dscp_q, 2'b00};
            16: return ip_len[15:8];
            17: return ip_len[7:0];
            22: return 8'd64;
            23: return proto_of(kind_q);
            24: return lat_csum[15:8];
            25: return lat_csum[7:0];
            26: return 8'hC0;
            27: return 8'hA8;
            28: return 8'h01;
            29: return 8'h01;
            30: return dest_addr_q[31:24];
            31: return dest_addr_q[23:16];
            32: return dest_addr_q[15:8];
            33: return dest_addr_q[7:0];
            default: ;
        endcase
        if (pos < 34) return 8'h00;
        if (kind_q == KIND_UDP || kind_q == KIND_TCP) begin
            if (pos == 34) return lat_sport[15:8];
            if (pos == 35) return lat_sport[7:0];
            if (pos == 36) return dest_port_q[15:8];
            if (pos == 37) return dest_port_q[7:0];
        end
        if (kind_q == KIND_UDP) begin
            if (pos == 38) return udp_len[15:8];
            if (pos == 39) return udp_len[7:0];
            if (pos < 42) return 8'h00;
            case (fill_q)
                FILL_RANDOM: return rnd[63 - 8*lane -: 8];
                FILL_ZEROS:  return 8'h00;
                FILL_ONES:   return 8'hFF;
                default:     return 8'(pos - 42);
            endcase
        end
        if (kind_q == KIND_TCP) begin
            if (pos >= 38 && pos <= 41) return frame_seq[8*(41-pos) +: 8];
            if (pos == 46) return 8'h50;
            if (pos == 47) return 8'h02;
            if (pos == 48 || pos == 49) return 8'hFF;
            return 8'h00;
        end
        // ICMP echo, kind three included
        if (pos == 34) return 8'd8;
        if (pos == 38) return lat_ident[15:8];
        if (pos == 39) return lat_ident[7:0];
        if (pos == 40) return frame_seq[15:8];
        if (pos == 41) return frame_seq[7:0];
        return 8'h00;
    endfunction

    // advance the frame model by one accepted beat
    task automatic predict_word(logic [63:0] rnd, logic [15:0] ident);
        int          base, rem, nvalid;
        logic [16:0] span;
        logic [63:0] w;
        frame_beat_t e;
        if (word_idx == 0) begin
            span = (sport_hi_q >= sport_lo_q) ? 17'(sport_hi_q) - 17'(sport_lo_q) + 17'd1
                                              : 17'd1;
            lat_len = (frame_len_q < 11'd60) ? 11'd60 :
                      (frame_len_q > 11'd1514) ? 11'd1514 : frame_len_q;
            lat_sport = 16'(17'(sport_lo_q) + 17'(17'(rnd[15:0]) % span));
            lat_ident = ident;
            lat_csum  = ip_checksum(lat_len);
        end
        base = int'(word_idx) * 8;
        rem = (int'(lat_len) > base) ? int'(lat_len) - base : 1;
        nvalid = (rem <= 8) ? rem : 8;
        w = '0;
        for (int k = 0; k < 8; k++)
            w = {w[55:0], (k < nvalid) ? byte_at(base + k, rnd, k) : 8'h00};
        e.eof  = (rem <= 8);
        e.data = {4'd0, 4'(nvalid), w};
        expected_words.push_back(e);
        if (e.eof) begin
            word_idx = '0;
            frame_seq++;
        end else begin
            word_idx++;
        end
    endtask

    // one input beat; called at a falling edge, returns at a falling edge
    task automatic send_beat(logic [63:0] rnd, logic [15:0] ident);
        while (!steady && $urandom_range(99) < 28) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {ident, rnd};
        do @(posedge aclk); while (!s_tready);
        predict_word(rnd, ident);
        beats_in++;
        @(negedge aclk);
    endtask

    task automatic send_random(int n);
        repeat (n) send_beat({$urandom, $urandom}, 16'($urandom));
    endtask

    // stop sending and wait for every predicted word, then let the first-beat
    // pipeline settle so a register write cannot land on work in flight
    task automatic drain();
        s_tvalid = 1'b0;
        while (expected_words.size() != 0) @(negedge aclk);
        repeat (25) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
        cfg_we = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        case (idx)
            CFG_DEST_ADDRESS: dest_addr_q = val;
            CFG_DEST_PORT:    dest_port_q = val[15:0];
            CFG_SPORT_LOW:    sport_lo_q = val[15:0];
            CFG_SPORT_HIGH:   sport_hi_q = val[15:0];
            CFG_KIND:         kind_q = kind_t'(val[1:0]);
            CFG_FRAME_BYTES:  frame_len_q = val[10:0];
            CFG_DSCP:         dscp_q = val[5:0];
            default:          fill_q = fill_t'(val[1:0]);
        endcase
    endtask

    // finish the frame in progress so a test starts on word 0
    task automatic close_frame();
        while (word_idx != 0) send_random(1);
        drain();
    endtask

    task automatic test_reset_defaults();
        send_beat(64'h0, 16'h0);
        send_random(40);
        drain();
    endtask

    task automatic test_kinds();
        kind_t k;
        close_frame();
        write_reg(CFG_FRAME_BYTES, 32'd60);
        write_reg(CFG_DEST_ADDRESS, 32'hFFFF_FFFF);
        write_reg(CFG_DEST_PORT, 32'hFFFF);
        write_reg(CFG_DSCP, 32'd63);
        for (int i = 0; i < 4; i++) begin
            k = kind_t'(i);
            write_reg(CFG_KIND, {30'd0, k});
            send_beat({64{i[0]}}, {16{i[1]}});
            send_random(7);
            drain();
        end
    endtask

    task automatic test_lengths_and_fill();
        write_reg(CFG_KIND, {30'd0, KIND_UDP});
        write_reg(CFG_DEST_ADDRESS, 32'h0);
        write_reg(CFG_DSCP, 32'd0);
        write_reg(CFG_FRAME_BYTES, 32'd0);          // clamps up to 60
        write_reg(CFG_FILL_MODE, {30'd0, FILL_RANDOM});
        send_random(8);
        drain();
        write_reg(CFG_FRAME_BYTES, 32'd2047);       // clamps down to 1514
        write_reg(CFG_FILL_MODE, {30'd0, FILL_ONES});
        send_random(190);
        drain();
        write_reg(CFG_FRAME_BYTES, 32'd61);
        write_reg(CFG_FILL_MODE, {30'd0, FILL_ZEROS});
        send_random(8);
        drain();
    endtask

    task automatic test_source_port();
        write_reg(CFG_SPORT_LOW, 32'd40000);        // high below low: span of one
        write_reg(CFG_SPORT_HIGH, 32'd100);
        send_beat(64'hFFFF, 16'h0);
        send_random(7);
        drain();
        write_reg(CFG_SPORT_LOW, 32'd0);
        write_reg(CFG_SPORT_HIGH, 32'hFFFF);
        send_beat(64'hFFFF, 16'h0);
        send_random(7);
        drain();
    endtask

    // registers change while a frame is partly sent
    task automatic test_midframe_change();
        write_reg(CFG_FRAME_BYTES, 32'd64);
        send_random(3);
        drain();
        write_reg(CFG_FRAME_BYTES, 32'd1000);
        write_reg(CFG_KIND, {30'd0, KIND_TCP});
        write_reg(CFG_DEST_ADDRESS, 32'h0A00_0001);
        send_random(6);
        drain();
    endtask

    task automatic test_random_traffic();
        cfg_idx_t idx;
        logic [31:0] v;
        while (beats_in < 1600) begin
            repeat ($urandom_range(1, 3)) begin
                idx = cfg_idx_t'($urandom_range(7));
                v = $urandom;
                if (idx == CFG_FRAME_BYTES)
                    v = ($urandom_range(9) == 0) ? $urandom_range(2047)
                                                 : $urandom_range(50, 130);
                else if (idx == CFG_SPORT_LOW || idx == CFG_SPORT_HIGH)
                    v = ($urandom_range(3) == 0) ? {16'd0, 16'($urandom)}
                                                 : $urandom_range(1000, 1100);
                else if (idx == CFG_DEST_ADDRESS && $urandom_range(3) == 0)
                    v = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
                write_reg(idx, v);
            end
            steady = ($urandom_range(5) == 0);
            send_random($urandom_range(1, 60));
            drain();
            steady = 1'b0;
        end
    endtask

    always @(negedge aclk)
        m_tready <= steady || ($urandom_range(99) >= 28);

    always @(posedge aclk) begin
        frame_beat_t e;
        if (aresetn && m_tvalid && m_tready) begin
            beats_out++;
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected beat tdata=%h tlast=%b", $time, m_tdata, m_tlast);
                errors++;
            end else begin
                e = expected_words.pop_front();
                if (m_tdata[63:0] !== e.data[63:0]) begin
                    $display("%0t: frame_word expected %h actual %h",
                             $time, e.data[63:0], m_tdata[63:0]);
                    errors++;
                end
                if (m_tdata[71:64] !== e.data[71:64]) begin
                    $display("%0t: valid_bytes/pad expected %h actual %h",
                             $time, e.data[71:64], m_tdata[71:64]);
                    errors++;
                end
                if (m_tlast !== e.eof) begin
                    $display("%0t: tlast expected %b actual %b", $time, e.eof, m_tlast);
                    errors++;
                end
                if (e.eof) frames_out++;
            end
        end
    end

    // watchdog: cycles without any beat moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("%0t: timeout, %0d words outstanding", $time, expected_words.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        dest_addr_q = 32'hC0A80202;
        dest_port_q = 16'd5000;
        sport_lo_q  = 16'd10000;
        sport_hi_q  = 16'd10100;
        kind_q      = KIND_UDP;
        frame_len_q = 11'd1400;
        dscp_q      = '0;
        fill_q      = FILL_COUNT;
        word_idx    = '0;
        frame_seq   = '0;
        lat_sport   = '0;
        lat_csum    = '0;
        lat_ident   = '0;
        lat_len     = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_reset_defaults();
        test_kinds();
        test_lengths_and_fill();
        test_source_port();
        test_midframe_change();
        test_random_traffic();
        drain();
        $display("Sent %0d beats, got %0d beats in %0d complete frames", beats_in,
                 beats_out, frames_out);
        $display("Covered all transport kinds, fill modes, length clamps, port spans");
        if (errors == 0 && expected_words.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
